/* src/dma_allow_region_table_core_macros.svh */
// Assertion macros shared by the allow-region table RTL.
`ifndef DMA_ALLOW_REGION_TABLE_CORE_MACROS_SVH
`define DMA_ALLOW_REGION_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DARAT_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DARAT_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/darat_pkg.sv */
// Types and constants shared by the allow-region table modules.
`default_nettype none
package darat_pkg;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 44;
  localparam int BYTES_W  = 36;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int MASK_W   = 16;
  localparam int BASE_W   = 32;
  localparam int SIZE_W   = 24;
  localparam int FLAG_W   = 8;

  localparam logic [FLAG_W-1:0] ALLOW_BYTE = 8'hff;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_NO_FREE    = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_REM,
    S_WIPE,
    S_RESP
  } state_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [SIZE_W-1:0] size_pages;
    logic [BASE_W-1:0] base_page;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

/* src/darat_if.sv */
// Valid/ready channel interfaces: command in, result out, protect-mask write.
`default_nettype none
interface darat_in_if import darat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ADDR_W-1:0]  region_base;
  logic [BYTES_W-1:0] region_bytes;

  modport source (output valid, cmd, region_base, region_bytes, input ready);
  modport sink   (input valid, cmd, region_base, region_bytes, output ready);
endinterface

interface darat_out_if import darat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

interface darat_cfg_if import darat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] protected_mask;

  modport source (output valid, protected_mask, input ready);
  modport sink   (input valid, protected_mask, output ready);
endinterface
`default_nettype wire

/* src/darat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module darat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output      logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/darat_match.sv */
// Shared compare unit: exact base/size match of one entry against the key.
`default_nettype none
module darat_match import darat_pkg::*; (
  input  wire entry_t            entry,
  input  wire logic [BASE_W-1:0] key_base,
  input  wire logic [SIZE_W-1:0] key_size,
  output      logic              hit
);
  assign hit = (entry.base_page == key_base) && (entry.size_pages == key_size);
endmodule
`default_nettype wire

/* src/dma_allow_region_table_core.sv */
// Top level of the DMA allow-region table: sequencer, in-use marks, entry RAM.
//
//  channel | dir | payload                              | accepted when
//  --------+-----+--------------------------------------+-------------------------
//  in_ch   | in  | cmd, region_base, region_bytes       | valid & ready (idle only)
//  out_ch  | out | status, slot                         | valid & ready
//  cfg_ch  | in  | protected_mask                       | valid & ready (always ready)
//
// Scans: add checks one entry per cycle until it finds a free one or reaches
// the last, then loads the result word. Remove reads the entry RAM one address
// per cycle through the compare unit, then loads the result word. Clear-all
// sweeps all ENTRIES slots, one per cycle, then loads it. Misaligned add and
// remove words and no-op words skip the scan and only load the result word. The
// single RAM read port and the one compare unit set the scan length.
// Reset: synchronous, clears in-use marks, protect mask and handshake state;
// RAM contents are only read for in-use entries and need no clearing.
// Stalls: a result word waits in the output register; a new command word is
// taken while it waits, and the block holds in its response step only if a
// second result is ready before the first is taken.
`default_nettype none
`include "dma_allow_region_table_core_macros.svh"
module dma_allow_region_table_core import darat_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_SHIFT = 12
) (
  input wire logic   clk,
  input wire logic   rst_n,
  darat_in_if.sink   in_ch,
  darat_out_if.source out_ch,
  darat_cfg_if.sink  cfg_ch
);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0]   CNT_END   = CNT_W'(ENTRIES);
  localparam logic [ADDR_W-1:0]  BASE_LOW  = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);
  localparam logic [BYTES_W-1:0] BYTES_LOW = (BYTES_W'(1) << PAGE_SHIFT) - BYTES_W'(1);

  // Zero-extend or truncate an entry index to the slot field.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  // ---------------------------------------------------------------- state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ENTRIES-1:0]  in_use_r, in_use_nxt;
  logic [MASK_W-1:0]   prot_mask_r;
  logic                chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                out_vld_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [BASE_W-1:0]   key_base_r;
  logic [SIZE_W-1:0]   key_size_r;

  // ---------------------------------------------------------------- decode
  logic               in_acc;
  logic               misaligned;
  logic [ADDR_W-1:0]  base_sh;
  logic [BYTES_W-1:0] bytes_sh;
  cmd_t               in_cmd;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_cmd      = cmd_t'(in_ch.cmd);
  assign misaligned  = ((in_ch.region_base & BASE_LOW) != '0) ||
                       ((in_ch.region_bytes & BYTES_LOW) != '0);
  assign base_sh     = in_ch.region_base >> PAGE_SHIFT;
  assign bytes_sh    = in_ch.region_bytes >> PAGE_SHIFT;

  // Entries past the mask width can never be protected.
  logic [ENTRIES-1:0] prot_vec;
  for (genvar g = 0; g < ENTRIES; g++) begin : g_prot
    if (g < MASK_W) begin : g_in
      assign prot_vec[g] = prot_mask_r[g];
    end else begin : g_out
      assign prot_vec[g] = 1'b0;
    end
  end

  // ---------------------------------------------------------------- RAM + compare
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic             match_hit;

  darat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  darat_match u_match (
    .entry    (ram_rdata),
    .key_base (key_base_r),
    .key_size (key_size_r),
    .hit      (match_hit)
  );

  // ---------------------------------------------------------------- scan status
  logic [IDX_W-1:0] cur_idx;
  logic             cur_free, cur_last;
  logic             chk_hit, chk_last;
  logic             rd_more;
  logic             out_free;

  assign cur_idx  = cnt_r[IDX_W-1:0];
  assign cur_free = !prot_vec[cur_idx] && !in_use_r[cur_idx];
  assign cur_last = (cur_idx == LAST_IDX);
  // RAM data arrives the cycle after its read address; chk_* tracks it.
  assign chk_hit  = chk_vld_r && match_hit && !prot_vec[chk_idx_r] && in_use_r[chk_idx_r];
  assign chk_last = chk_vld_r && (chk_idx_r == LAST_IDX);
  assign rd_more  = (cnt_r < CNT_END);
  assign out_free = !out_vld_r || out_ch.ready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_ADD:    state_nxt = misaligned ? S_RESP : S_ADD;
            CMD_REMOVE: state_nxt = misaligned ? S_RESP : S_REM;
            CMD_CLEAR:  state_nxt = S_WIPE;
            CMD_NOP:    state_nxt = S_RESP;
            default:    state_nxt = S_RESP;
          endcase
        end
      end
      S_ADD: begin
        if (cur_free || cur_last) state_nxt = S_RESP;
      end
      S_REM: begin
        if (chk_hit || chk_last) state_nxt = S_RESP;
      end
      S_WIPE: begin
        if (cur_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath control
  always_comb begin
    cnt_nxt        = cnt_r;
    in_use_nxt     = in_use_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = cur_idx;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_idx;
    ram_wdata      = '0;
    ram_raddr      = cur_idx;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          res_status_nxt = misaligned && (in_cmd == CMD_ADD || in_cmd == CMD_REMOVE)
                           ? ST_MISALIGNED : ST_OK;
          res_slot_nxt   = '0;
        end
      end
      S_ADD: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cur_free) begin
          ram_we               = 1'b1;
          ram_wdata.base_page  = key_base_r;
          ram_wdata.size_pages = key_size_r;
          ram_wdata.flags      = ALLOW_BYTE;
          in_use_nxt[cur_idx]  = 1'b1;
          res_status_nxt       = ST_OK;
          res_slot_nxt         = to_slot(cur_idx);
        end else if (cur_last) begin
          res_status_nxt = ST_NO_FREE;
          res_slot_nxt   = '0;
        end
      end
      S_REM: begin
        if (rd_more) begin
          cnt_nxt     = cnt_r + CNT_W'(1);
          chk_vld_nxt = !chk_hit && !chk_last;
        end
        if (chk_hit) begin
          ram_we                = 1'b1;
          ram_waddr             = chk_idx_r;
          in_use_nxt[chk_idx_r] = 1'b0;
          res_status_nxt        = ST_OK;
          res_slot_nxt          = to_slot(chk_idx_r);
        end else if (chk_last) begin
          res_status_nxt = ST_NOT_FOUND;
          res_slot_nxt   = '0;
        end
      end
      S_WIPE: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (!prot_vec[cur_idx]) begin
          ram_we              = 1'b1;
          in_use_nxt[cur_idx] = 1'b0;
        end
        if (cur_last) begin
          res_status_nxt = ST_OK;
          res_slot_nxt   = '0;
        end
      end
      S_RESP: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      in_use_r     <= '0;
      prot_mask_r  <= '0;
      chk_vld_r    <= 1'b0;
      out_vld_r    <= 1'b0;
      res_status_r <= ST_OK;
      res_slot_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      in_use_r     <= in_use_nxt;
      chk_vld_r    <= chk_vld_nxt;
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      if (cfg_ch.valid) begin
        prot_mask_r <= cfg_ch.protected_mask;
      end
      if (state_r == S_RESP && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    if (in_acc) begin
      key_base_r <= base_sh[BASE_W-1:0];
      key_size_r <= bytes_sh[SIZE_W-1:0];
    end
    if (state_r == S_RESP && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_vld_r;
  assign out_ch.status = out_status_r;
  assign out_ch.slot   = out_slot_r;

  // ---------------------------------------------------------------- checks
  `DARAT_CHK_NOW(a_prot_never_claimed, $past(rst_n), ((in_use_r & ~$past(in_use_r) & $past(prot_vec)) == '0), "protected entry marked in use")
  `DARAT_CHK_NOW(a_one_mark_per_cycle, $past(rst_n), ($countones(in_use_r ^ $past(in_use_r)) <= 1), "more than one in-use mark changed in a cycle")
  `DARAT_CHK_NOW(a_ram_write_in_scan, ram_we, (state_r == S_ADD || state_r == S_REM || state_r == S_WIPE), "entry RAM written outside a scan")
  `DARAT_CHK_NEXT(a_accept_leaves_idle, in_acc, (state_r != S_IDLE), "command word accepted but sequencer stayed idle")
endmodule
`default_nettype wire
